@@ rtl/hbw_pkg.sv @@
// Package for the heartbeat watchdog: field widths, register indexes,
// phase and event codes and the configuration and result structs.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package hbw_pkg;

  // Width of the heartbeat word that is compared (8 to 64).
  localparam int HB_W       = 32;
  localparam int SAMPLE_W   = 32;
  localparam int MISS_W     = 10;
  localparam int THR_W      = 32;
  localparam int WIN_W      = 11;
  localparam int CNT_W      = 16;
  localparam int EV_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int IN_FIELDS_W  = SAMPLE_W + 1;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + CNT_W + EV_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [MISS_W-1:0] MISS_LIMIT_RST = MISS_W'(50);
  localparam logic [THR_W-1:0]  PROOF_THR_RST  = THR_W'(1000000);
  localparam logic [WIN_W-1:0]  WIN_POLLS_RST  = WIN_W'(100);
  localparam logic              WIN_EN_RST     = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MISS_LIMIT = 2'd0,
    REG_PROOF_THR  = 2'd1,
    REG_WIN_POLLS  = 2'd2,
    REG_WIN_EN     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_MON  = 2'd1,
    PH_LOST = 2'd2,
    PH_WIN  = 2'd3
  } phase_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE   = 3'd0,
    EV_ARMED  = 3'd1,
    EV_LOST   = 3'd2,
    EV_REC    = 3'd3,
    EV_PROVEN = 3'd4,
    EV_PASS   = 3'd5,
    EV_FAIL   = 3'd6
  } event_t;

  typedef struct packed {
    logic [MISS_W-1:0] miss_limit;
    logic [THR_W-1:0]  proof_threshold;
    logic [WIN_W-1:0]  window_polls;
    logic              window_en;
  } cfg_t;

  typedef struct packed {
    event_t           event_code;
    logic [CNT_W-1:0] recovery_count;
    logic             trip_flag;
  } res_t;

  // Low HB_W bits of the sign-extended sample.
  function automatic logic [HB_W-1:0] hb_word(input logic signed [SAMPLE_W-1:0] sample);
    logic signed [63:0] wide;
    wide = 64'(sample);
    return wide[HB_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/hbw_core.sv @@
// Watchdog state and the per-poll update: phase, baseline, miss and
// window counters, recovery count and kill flag. Uses hbw_pkg.
// The state advances only on a step; the result is its combinational view.
`timescale 1ns / 1ps
`default_nettype none

module hbw_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               step,
  input  hbw_pkg::cfg_t                     cfg,
  input  wire signed [hbw_pkg::SAMPLE_W-1:0] sample,
  input  wire                               ready_seen,
  output hbw_pkg::res_t                     res
);
  import hbw_pkg::*;

  phase_t            phase_r,  phase_nxt;
  logic [HB_W-1:0]   last_r,   last_nxt;
  logic [MISS_W-1:0] miss_r,   miss_nxt;
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic [WIN_W-1:0]  win_r,    win_nxt;
  logic              done_r,   done_nxt;
  logic              kill_r,   kill_nxt;
  event_t            ev;

  logic [HB_W-1:0]    cur;
  logic signed [63:0] cur_wide;
  logic signed [63:0] thr_wide;
  logic               same;
  logic [MISS_W-1:0]  miss_inc;
  logic [WIN_W-1:0]   win_inc;
  logic               miss_hit;
  logic               proven;
  logic               fail;

  assign cur      = hb_word(sample);
  assign cur_wide = 64'(signed'(cur));
  assign thr_wide = 64'(signed'(cfg.proof_threshold));
  assign same     = (cur == last_r);
  assign miss_inc = (miss_r == '1) ? miss_r : miss_r + MISS_W'(1);
  assign win_inc  = (win_r == '1) ? win_r : win_r + WIN_W'(1);
  assign miss_hit = (miss_inc >= cfg.miss_limit);
  assign proven   = (cur_wide >= thr_wide);
  assign fail     = same && miss_hit;

  always_comb begin
    phase_nxt = phase_r;
    last_nxt  = last_r;
    miss_nxt  = miss_r;
    cnt_nxt   = cnt_r;
    win_nxt   = win_r;
    done_nxt  = done_r;
    kill_nxt  = kill_r;
    ev        = EV_NONE;
    unique case (phase_r)
      PH_WAIT: begin
        if (ready_seen) begin
          last_nxt  = cur;
          miss_nxt  = '0;
          phase_nxt = PH_MON;
          ev        = EV_ARMED;
        end
      end
      PH_MON: begin
        if (same) begin
          miss_nxt = miss_inc;
          if (miss_hit) begin
            kill_nxt  = 1'b1;
            phase_nxt = PH_LOST;
            ev        = EV_LOST;
          end
        end else begin
          miss_nxt = '0;
          last_nxt = cur;
        end
      end
      PH_LOST: begin
        if (!same) begin
          kill_nxt = 1'b0;
          ev       = EV_REC;
          if (proven) begin
            if (cnt_r != '1) cnt_nxt = cnt_r + CNT_W'(1);
            ev = EV_PROVEN;
          end
          last_nxt = cur;
          miss_nxt = '0;
          // Window only if enabled, the count is one and no window passed yet.
          if (!done_r && cnt_nxt == CNT_W'(1) && cfg.window_en) begin
            win_nxt   = '0;
            phase_nxt = PH_WIN;
          end else begin
            phase_nxt = PH_MON;
          end
        end
      end
      PH_WIN: begin
        if (same) begin
          miss_nxt = miss_inc;
        end else begin
          miss_nxt = '0;
          last_nxt = cur;
        end
        if (fail) begin
          ev = EV_FAIL;
        end else begin
          win_nxt = win_inc;
          if (win_inc >= cfg.window_polls) begin
            ev       = EV_PASS;
            done_nxt = 1'b1;
          end
        end
        if (ev == EV_FAIL || ev == EV_PASS) begin
          last_nxt  = cur;
          miss_nxt  = '0;
          win_nxt   = '0;
          phase_nxt = PH_MON;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      last_r  <= '0;
      miss_r  <= '0;
      cnt_r   <= '0;
      win_r   <= '0;
      done_r  <= 1'b0;
      kill_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      last_r  <= last_nxt;
      miss_r  <= miss_nxt;
      cnt_r   <= cnt_nxt;
      win_r   <= win_nxt;
      done_r  <= done_nxt;
      kill_r  <= kill_nxt;
    end
  end

  assign res.trip_flag      = kill_nxt;
  assign res.recovery_count = cnt_nxt;
  assign res.event_code     = ev;

endmodule

`default_nettype wire

@@ rtl/heartbeat_watchdog_recovery.sv @@
// Heartbeat-miss watchdog with recovery proof and a stability window.
// Usage:
//   Each request on the in_ stream is one poll tick: the sampled heartbeat
//   word and the ready flag. Every tick yields exactly one result on the out_
//   stream: the kill flag, the saturating recovery count and an event code.
//   Registers are written through the cfg_ port (index 0 miss limit, 1 proof
//   threshold, 2 window length, 3 window enable) while the block is idle.
// Path: an accepted tick passes the input register, then the result register,
//   which is loaded with the state update; out_ offers the result from there.
// Throughput: one tick per cycle while results are taken; the state update is
//   a single compare and counter step between the input and result registers.
// Reset (rst_n low, synchronous): both stages empty, watchdog waits for ready,
//   counters cleared, registers at 50, 1000000, 100 and 1.
// Stall: while a result is offered and not taken the result register holds;
//   an empty input register still takes one more tick, after which in_tready
//   falls until the result is taken.
// Depends on hbw_pkg and hbw_core.
`timescale 1ns / 1ps
`default_nettype none

module heartbeat_watchdog_recovery (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // in_tdata: heartbeat_sample [31:0], ready_seen [32], zero fill [39:33]
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [hbw_pkg::IN_TDATA_W-1:0]       in_tdata,
  // out_tdata: trip_flag [0], recovery_count [16:1], event_code [19:17],
  // zero fill [23:20]
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [hbw_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire                                  cfg_wr_en,
  input  wire  [hbw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [hbw_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import hbw_pkg::*;

  cfg_t                 cfg_r;
  logic                 s1_valid_r;
  logic [SAMPLE_W-1:0]  s1_sample_r;
  logic                 s1_ready_r;
  logic                 out_valid_r;
  res_t                 out_res_r;
  res_t                 res;
  logic                 out_free;
  logic                 step;
  logic                 in_acc;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.miss_limit      <= MISS_LIMIT_RST;
      cfg_r.proof_threshold <= PROOF_THR_RST;
      cfg_r.window_polls    <= WIN_POLLS_RST;
      cfg_r.window_en       <= WIN_EN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MISS_LIMIT: cfg_r.miss_limit      <= cfg_wdata[MISS_W-1:0];
        REG_PROOF_THR:  cfg_r.proof_threshold <= cfg_wdata[THR_W-1:0];
        REG_WIN_POLLS:  cfg_r.window_polls    <= cfg_wdata[WIN_W-1:0];
        REG_WIN_EN:     cfg_r.window_en       <= cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (step) begin
        s1_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_tdata[SAMPLE_W-1:0];
      s1_ready_r  <= in_tdata[SAMPLE_W];
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  hbw_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .cfg        (cfg_r),
    .sample     (signed'(s1_sample_r)),
    .ready_seen (s1_ready_r),
    .res        (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_res_r.event_code, out_res_r.recovery_count,
                                    out_res_r.trip_flag});

endmodule

`default_nettype wire

@@ rtl/hbw_checker.sv @@
// Port-level checks for the heartbeat watchdog, bound to the top level.
// Uses hbw_pkg for the event codes and the stream widths.
`timescale 1ns / 1ps
`default_nettype none

module hbw_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_tvalid,
  input wire                               in_tready,
  input wire                               out_tvalid,
  input wire                               out_tready,
  input wire [hbw_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import hbw_pkg::*;

  logic [EV_W-1:0] ev;
  assign ev = out_tdata[CNT_W+EV_W:CNT_W+1];

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // Losing the heartbeat always shows the kill flag raised.
  a_lost_kill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ev == EV_LOST |-> out_tdata[0])
    else $error("lost event without kill flag");

  // Any recovery clears the kill flag.
  a_rec_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (ev == EV_REC || ev == EV_PROVEN) |-> !out_tdata[0])
    else $error("recovery event with kill flag still set");

  // No result can appear in the cycle after reset.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  // A tick taken while out_ is empty is answered via both registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |-> ##2 out_tvalid)
    else $error("tick not answered in time");

endmodule

bind heartbeat_watchdog_recovery hbw_checker u_hbw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
